// ===== src/irlpe_pkg.sv =====
// Shared types and constants for the IR line position estimator.
// Used by irlpe_div, the top level and the bench; depends on nothing else.
package irlpe_pkg;

  localparam int RES_W       = 10;  // width of resolution, threshold and a normalised reading
  localparam int POS_W       = 13;  // width of the signed line position
  localparam int CNT_OUT_W   = 3;   // width of the reported active count
  localparam int OUT_DATA_W  = 16;  // result tdata: position and count, byte aligned
  localparam int POS_MAX     = 4095;
  localparam int POS_MIN_MAG = 4096;
  localparam int CNT_OUT_MAX = 7;

  localparam logic [RES_W-1:0] RES_RESET = 10'd100;
  localparam logic [RES_W-1:0] THR_RESET = 10'd60;

  typedef enum logic [0:0] {
    REG_RESOLUTION = 1'b0,
    REG_THRESHOLD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_NORM_WAIT,
    ST_ACC,
    ST_POS,
    ST_POS_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/irlpe_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on irlpe_pkg for its status struct.
module irlpe_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [NUM_W-1:0]     quot,
  output irlpe_pkg::div_stat_t stat
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] d;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {r, q[NUM_W-1]};
  assign diff  = trial - {1'b0, d};
  assign ge    = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top of q while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      if (ge) begin
        r <= diff[DEN_W-1:0];
        q <= {q[NUM_W-2:0], 1'b1};
      end else begin
        r <= trial[DEN_W-1:0];
        q <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot      = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== src/irlpe_ext.sv =====
// Per-channel calibration extremes: running maximum and minimum of each channel.
// Depends on irlpe_pkg only through the naming of the project.
module irlpe_ext #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cal_we,
  input  logic [CHANNELS*SAMPLE_BITS-1:0] cal_samples,
  input  logic [$clog2(CHANNELS)-1:0]     rd_chan,
  output logic [SAMPLE_BITS-1:0]          rd_max,
  output logic [SAMPLE_BITS-1:0]          rd_min
);

  logic [SAMPLE_BITS-1:0] channel_max [CHANNELS];
  logic [SAMPLE_BITS-1:0] channel_min [CHANNELS];

  // Every channel is widened in the same cycle; after reset max sits below min.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        channel_max[i] <= '0;
        channel_min[i] <= '1;
      end
    end else if (cal_we) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (cal_samples[i*SAMPLE_BITS +: SAMPLE_BITS] > channel_max[i]) begin
          channel_max[i] <= cal_samples[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
        if (cal_samples[i*SAMPLE_BITS +: SAMPLE_BITS] < channel_min[i]) begin
          channel_min[i] <= cal_samples[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
      end
    end
  end

  assign rd_max = channel_max[rd_chan];
  assign rd_min = channel_min[rd_chan];

endmodule

// ===== src/ir_line_position_estimator.sv =====
// Channel     Direction  Contents
// s_*         in         tuser: kind; tdata: sample_0 .. sample_(CHANNELS-1)
// m_*         out        tuser: uncalibrated; tdata: line_position, active_count
// cfg_*       in         write of resolution (index 0) or on_line_threshold (index 1)
//
// A calibration transaction is written to the extremes as it is accepted. A measure transaction
// takes each channel through one shared serial divider (start, the divider steps over the NUM_W =
// 10 + SAMPLE_BITS dividend bits, done, accumulate), or from start straight to accumulate if there
// is nothing to divide, then averages the same way. Reset clears the extremes (maximum 0, minimum
// all ones) and loads the registers with 100 and 60. Input is taken only while idle; a result waits
// in the output register and the next one holds the sequencer until it has been taken.
// Top level of the IR line position estimator; uses irlpe_pkg, irlpe_ext, irlpe_div.
module ir_line_position_estimator #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample_0 upwards, zero fill
  input  logic                                  s_tuser,   // kind
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [irlpe_pkg::OUT_DATA_W-1:0]      m_tdata,   // line_position, active_count
  output logic                                  m_tuser,   // uncalibrated
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [irlpe_pkg::RES_W-1:0]           cfg_data
);

  localparam int RES_W = irlpe_pkg::RES_W;
  localparam int POS_W = irlpe_pkg::POS_W;
  localparam int SMP_W = CHANNELS * SAMPLE_BITS;
  localparam int CH_W  = $clog2(CHANNELS);
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int NUM_W = RES_W + SAMPLE_BITS;
  localparam int DEN_W = SAMPLE_BITS;
  localparam int WGT_W = CH_W + 2;
  localparam int SUM_W = RES_W + 2 * CH_W + 1;

  irlpe_pkg::state_t    state;
  irlpe_pkg::state_t    state_next;
  irlpe_pkg::div_stat_t div_stat;

  logic [RES_W-1:0]       resolution;
  logic [RES_W-1:0]       threshold;
  logic [SMP_W-1:0]       samples;
  logic [CH_W-1:0]        chan;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]       count;
  logic                   flag;
  logic [RES_W-1:0]       norm;

  logic                   accept;
  logic                   last_chan;
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic [SAMPLE_BITS-1:0] cur_max;
  logic [SAMPLE_BITS-1:0] cur_min;
  logic                   degenerate;
  logic                   skip;
  logic [NUM_W-1:0]       prod;
  logic [NUM_W-1:0]       quot;
  logic [RES_W-1:0]       norm_clamped;
  logic signed [WGT_W-1:0] weight;
  logic signed [SUM_W-1:0] w_ext;
  logic signed [SUM_W-1:0] n_ext;
  logic signed [SUM_W-1:0] term;
  logic [SUM_W-1:0]       sum_mag;
  logic [POS_W-1:0]       pos_val;
  logic [irlpe_pkg::CNT_OUT_W-1:0] cnt_val;

  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   cal_we;
  logic                   load_out;

  irlpe_ext #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ext (
    .clk         (clk),
    .rst         (rst),
    .cal_we      (cal_we),
    .cal_samples (s_tdata[SMP_W-1:0]),
    .rd_chan     (chan),
    .rd_max      (cur_max),
    .rd_min      (cur_min)
  );

  irlpe_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .stat  (div_stat)
  );

  assign s_tready   = (state == irlpe_pkg::ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign last_chan  = (chan == CH_W'(CHANNELS - 1));
  assign cur_sample = samples[chan*SAMPLE_BITS +: SAMPLE_BITS];
  assign degenerate = (cur_max <= cur_min);
  assign skip       = degenerate || (cur_sample >= cur_max);
  assign prod       = NUM_W'(resolution) * NUM_W'(cur_max - cur_sample);

  assign norm_clamped = (quot > NUM_W'(resolution)) ? resolution : quot[RES_W-1:0];

  // Channel weight is 2*chan - (CHANNELS-1), symmetric about the centre.
  assign weight = $signed({1'b0, chan, 1'b0}) - $signed(WGT_W'(CHANNELS - 1));
  assign w_ext  = SUM_W'(weight);
  assign n_ext  = $signed(SUM_W'(norm));
  assign term   = w_ext * n_ext;

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // Average rounds toward zero because the magnitude is divided before the sign returns.
  always_comb begin
    if (count == '0) begin
      pos_val = '0;
    end else if (sum[SUM_W-1]) begin
      if (quot > NUM_W'(irlpe_pkg::POS_MIN_MAG)) begin
        pos_val = POS_W'(irlpe_pkg::POS_MIN_MAG);
      end else begin
        pos_val = POS_W'(0) - quot[POS_W-1:0];
      end
    end else begin
      if (quot > NUM_W'(irlpe_pkg::POS_MAX)) begin
        pos_val = POS_W'(irlpe_pkg::POS_MAX);
      end else begin
        pos_val = quot[POS_W-1:0];
      end
    end
  end

  assign cnt_val = (int'(count) > irlpe_pkg::CNT_OUT_MAX) ?
                   irlpe_pkg::CNT_OUT_W'(irlpe_pkg::CNT_OUT_MAX) :
                   irlpe_pkg::CNT_OUT_W'(count);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      irlpe_pkg::ST_IDLE: begin
        if (accept && s_tuser) begin
          state_next = irlpe_pkg::ST_NORM;
        end
      end
      irlpe_pkg::ST_NORM: begin
        state_next = skip ? irlpe_pkg::ST_ACC : irlpe_pkg::ST_NORM_WAIT;
      end
      irlpe_pkg::ST_NORM_WAIT: begin
        if (div_stat.done) begin
          state_next = irlpe_pkg::ST_ACC;
        end
      end
      irlpe_pkg::ST_ACC: begin
        state_next = last_chan ? irlpe_pkg::ST_POS : irlpe_pkg::ST_NORM;
      end
      irlpe_pkg::ST_POS: begin
        state_next = (count == '0) ? irlpe_pkg::ST_DONE : irlpe_pkg::ST_POS_WAIT;
      end
      irlpe_pkg::ST_POS_WAIT: begin
        if (div_stat.done) begin
          state_next = irlpe_pkg::ST_DONE;
        end
      end
      irlpe_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = irlpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = irlpe_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    div_start = 1'b0;
    div_num   = prod;
    div_den   = cur_max - cur_min;
    cal_we    = 1'b0;
    load_out  = 1'b0;
    case (state)
      irlpe_pkg::ST_IDLE: begin
        cal_we = accept && !s_tuser;
      end
      irlpe_pkg::ST_NORM: begin
        div_start = !skip;
      end
      irlpe_pkg::ST_POS: begin
        div_start = (count != '0);
        div_num   = NUM_W'(sum_mag);
        div_den   = DEN_W'(count);
      end
      irlpe_pkg::ST_DONE: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= irlpe_pkg::ST_IDLE;
      resolution <= irlpe_pkg::RES_RESET;
      threshold  <= irlpe_pkg::THR_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == irlpe_pkg::REG_RESOLUTION) begin
          resolution <= cfg_data;
        end else if (cfg_index == irlpe_pkg::REG_THRESHOLD) begin
          threshold <= cfg_data;
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser) begin
      samples <= s_tdata[SMP_W-1:0];
      chan    <= '0;
      sum     <= '0;
      count   <= '0;
      flag    <= 1'b0;
    end
    if (state == irlpe_pkg::ST_NORM) begin
      if (degenerate) begin
        flag <= 1'b1;
      end
      if (skip) begin
        norm <= '0;
      end
    end
    if (state == irlpe_pkg::ST_NORM_WAIT && div_stat.done) begin
      norm <= norm_clamped;
    end
    if (state == irlpe_pkg::ST_ACC) begin
      if (norm >= threshold) begin
        sum   <= sum + term;
        count <= count + CNT_W'(1);
      end
      if (!last_chan) begin
        chan <= chan + CH_W'(1);
      end
    end
    if (load_out) begin
      m_tdata <= {cnt_val, pos_val};
      m_tuser <= flag;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ir_line_position_estimator: writes the registers, drives sensor frames on the
// input stream, predicts each line position and checks the result stream.
// Depends on irlpe_pkg and the top level under src only.
module testbench;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_W    = 10;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_LEN    = 800;
  localparam int POS_W       = irlpe_pkg::POS_W;
  localparam int CNT_OUT_W   = irlpe_pkg::CNT_OUT_W;
  localparam int OUT_DATA_W  = irlpe_pkg::OUT_DATA_W;
  localparam int RES_W       = irlpe_pkg::RES_W;
  localparam int POS_MAX     = irlpe_pkg::POS_MAX;
  localparam int POS_MIN_MAG = irlpe_pkg::POS_MIN_MAG;
  localparam int CNT_OUT_MAX = irlpe_pkg::CNT_OUT_MAX;

  typedef enum logic {
    KIND_CALIBRATE = 1'b0,
    KIND_MEASURE   = 1'b1
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t                        kind;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  samples;
  } sensor_frame_t;

  typedef struct packed {
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] active;
    logic                 uncal;
  } line_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [CHANNELS*SAMPLE_W-1:0]  s_tdata = '0;  // sample_0 .. sample_3
  logic                          s_tuser = 1'b0;  // kind
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]         m_tdata;  // line_position, active_count
  logic                          m_tuser;  // uncalibrated
  logic                          cfg_we = 1'b0;
  logic [0:0]                    cfg_index = '0;
  logic [RES_W-1:0]              cfg_data = '0;

  sensor_frame_t frame_queue[$];
  line_result_t  pending_positions[$];
  sensor_frame_t held_frame;

  int unsigned   cfg_resolution = irlpe_pkg::RES_RESET;
  int unsigned   cfg_threshold  = irlpe_pkg::THR_RESET;
  logic [SAMPLE_W-1:0] ch_max[CHANNELS];
  logic [SAMPLE_W-1:0] ch_min[CHANNELS];

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          hold_req = 1'b0;
  logic          hold_done = 1'b0;
  int unsigned   hold_cycles = 0;
  int unsigned   error_count = 0;

  ir_line_position_estimator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      ch_max[i] = '0;
      ch_min[i] = '1;
    end
  end

  // Calibration frames widen the stored extremes; measure frames yield one expected result.
  function automatic void estimate_position(input sensor_frame_t f);
    int unsigned hi;
    int unsigned lo;
    int unsigned smp;
    int unsigned norm;
    int unsigned count;
    int          weighted_sum;
    int          pos;
    logic        uncal;
    line_result_t r;
    count = 0;
    weighted_sum = 0;
    pos = 0;
    uncal = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      hi  = ch_max[i];
      lo  = ch_min[i];
      smp = f.samples[i];
      if (f.kind == KIND_CALIBRATE) begin
        if (hi < smp) ch_max[i] = f.samples[i];
        if (lo > smp) ch_min[i] = f.samples[i];
      end else begin
        if (hi <= lo) begin
          uncal = 1'b1;
          norm = 0;
        end else if (smp >= hi) begin
          norm = 0;
        end else begin
          norm = (cfg_resolution * (hi - smp)) / (hi - lo);
          if (norm > cfg_resolution) norm = cfg_resolution;
        end
        if (norm >= cfg_threshold) begin
          weighted_sum += (2 * i - (CHANNELS - 1)) * int'(norm);
          count++;
        end
      end
    end
    if (f.kind == KIND_MEASURE) begin
      if (count != 0) pos = weighted_sum / int'(count);
      if (pos > POS_MAX) pos = POS_MAX;
      if (pos < -POS_MIN_MAG) pos = -POS_MIN_MAG;
      r.position = pos[POS_W-1:0];
      r.active   = (count > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX) : CNT_OUT_W'(count);
      r.uncal    = uncal;
      pending_positions.push_back(r);
    end
  endfunction

  // Sender: predicts on each accepted transaction, then offers the next frame or idles.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) estimate_position(held_frame);
      if (!s_tvalid || s_tready) begin
        if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_frame = frame_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= held_frame.samples;
          s_tuser  <= held_frame.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_cycles == HOLD_LEN) hold_done <= 1'b1;
      else hold_cycles <= hold_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(hold_req && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_positions.size() == 0) begin
        $error("result with nothing expected: line_position %0d", $signed(m_tdata[POS_W-1:0]));
        error_count++;
      end else begin
        exp_r = pending_positions.pop_front();
        if (m_tdata[POS_W-1:0] !== exp_r.position) begin
          $error("line_position: expected %0d, got %0d", $signed(exp_r.position),
                 $signed(m_tdata[POS_W-1:0]));
          error_count++;
        end
        if (m_tdata[POS_W +: CNT_OUT_W] !== exp_r.active) begin
          $error("active_count: expected %0d, got %0d", exp_r.active,
                 m_tdata[POS_W +: CNT_OUT_W]);
          error_count++;
        end
        if (m_tuser !== exp_r.uncal) begin
          $error("uncalibrated: expected %0b, got %0b", exp_r.uncal, m_tuser);
          error_count++;
        end
      end
    end
  end

  task automatic add_frame(input frame_kind_t k, input int a, input int b, input int c,
                           input int d);
    sensor_frame_t f;
    f.kind = k;
    f.samples[0] = a[SAMPLE_W-1:0];
    f.samples[1] = b[SAMPLE_W-1:0];
    f.samples[2] = c[SAMPLE_W-1:0];
    f.samples[3] = d[SAMPLE_W-1:0];
    frame_queue.push_back(f);
  endtask

  // Mostly a few calibration frames followed by a run of measures; some pure noise.
  task automatic add_random_frames(input int n);
    int added;
    int n_cal;
    int n_meas;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 10) begin
        add_frame(frame_kind_t'($urandom_range(1)), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
        added++;
      end else begin
        n_cal  = $urandom_range(2);
        n_meas = 2 + $urandom_range(4);
        repeat (n_cal) begin
          if ($urandom_range(7) == 0)
            add_frame(KIND_CALIBRATE, $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(1023));
          else
            add_frame(KIND_CALIBRATE, 150 + $urandom_range(700), 150 + $urandom_range(700),
                      150 + $urandom_range(700), 150 + $urandom_range(700));
        end
        repeat (n_meas)
          add_frame(KIND_MEASURE, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023), $urandom_range(1023));
        added += n_cal + n_meas;
      end
    end
  endtask

  // Calibration frames give no result, so the block may still be busy when the queue empties.
  task automatic wait_drained();
    do @(negedge clk);
    while (frame_queue.size() != 0 || s_tvalid || pending_positions.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_register(input irlpe_pkg::cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[RES_W-1:0];
    if (idx == irlpe_pkg::REG_RESOLUTION) cfg_resolution = val & 10'h3FF;
    else cfg_threshold = val & 10'h3FF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned res, input int unsigned thr);
    set_register(irlpe_pkg::REG_RESOLUTION, res);
    set_register(irlpe_pkg::REG_THRESHOLD, thr);
    @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 79;

    // Out of reset every channel is degenerate.
    add_frame(KIND_MEASURE, 0, 0, 0, 0);
    add_frame(KIND_MEASURE, 1023, 1023, 1023, 1023);
    add_frame(KIND_CALIBRATE, 100, 200, 300, 400);
    add_frame(KIND_MEASURE, 150, 250, 350, 450);
    // Channel 1 keeps equal extremes and stays flagged.
    add_frame(KIND_CALIBRATE, 900, 200, 700, 600);
    add_frame(KIND_MEASURE, 100, 200, 700, 450);
    add_frame(KIND_CALIBRATE, 0, 1023, 0, 1023);
    // Readings above the maximum and at the minimum hit the ends of the range.
    add_frame(KIND_MEASURE, 1023, 1023, 1023, 1023);
    add_frame(KIND_MEASURE, 0, 0, 0, 0);
    add_frame(KIND_MEASURE, 900, 500, 0, 1023);
    add_frame(KIND_MEASURE, 0, 1023, 1023, 1023);
    add_frame(KIND_MEASURE, 1023, 1023, 1023, 0);
    wait_drained();

    // Zero resolution: nothing can reach a non-zero threshold.
    configure(0, 5);
    add_frame(KIND_MEASURE, 0, 300, 600, 1023);
    add_frame(KIND_MEASURE, 450, 450, 450, 450);
    wait_drained();

    // Zero threshold: every channel counts.
    configure(200, 0);
    add_frame(KIND_MEASURE, 0, 1023, 0, 1023);
    add_frame(KIND_MEASURE, 800, 300, 200, 500);
    add_frame(KIND_MEASURE, 1023, 0, 1023, 0);
    wait_drained();

    configure(1000, 1);
    add_random_frames(100);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 38;
    configure(1, 1000);
    add_random_frames(60);
    wait_drained();

    configure(1023, 1023);
    add_random_frames(60);
    wait_drained();

    // No idling from here on; the long receiver hold-off backs the block up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure($urandom_range(1, 1000), $urandom_range(1, 1000));
    @(posedge clk);
    hold_req <= 1'b1;
    add_random_frames(80);
    wait_drained();

    configure(1000, 500);
    add_random_frames(100);
    wait_drained();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
src/irlpe_pkg.sv
src/irlpe_div.sv
src/irlpe_ext.sv
src/ir_line_position_estimator.sv
bench/testbench.sv
